// ===== rtl/core/lr_table_parse_engine_top_assert.svh =====
// Assertion macros used by the parse engine back end
`ifndef LR_TABLE_PARSE_ENGINE_TOP_ASSERT_SVH
`define LR_TABLE_PARSE_ENGINE_TOP_ASSERT_SVH
`ifndef SYNTH
`define LRP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lrp assertion failed");
`define LRP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lrp assertion failed");
`else
`define LRP_ASSERT_IMP(lbl, ante, cons)
`define LRP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/core/lrp_pkg.sv =====
// Types and constants of the LR table parse engine
package lrp_pkg;
	typedef enum logic [1:0] {
		OP_CELL  = 2'd0,
		OP_HEAD  = 2'd1,
		OP_RSYM  = 2'd2,
		OP_PARSE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_EMPTY  = 2'd0,
		KIND_SHIFT  = 2'd1,
		KIND_REDUCE = 2'd2,
		KIND_ACCEPT = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		V_NONE   = 2'd0,
		V_ACCEPT = 2'd1,
		V_REJECT = 2'd2
	} verdict_t;

	typedef enum logic [1:0] {
		C_NONE      = 2'd0,
		C_NO_ACTION = 2'd1,
		C_MISMATCH  = 2'd2,
		C_LIMIT     = 2'd3
	} cause_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK,
		ST_HEAD,
		ST_POP,
		ST_TOPRD,
		ST_GOTO,
		ST_FINISH
	} state_t;

	localparam logic [4:0]  RhsMax      = 5'd16;
	localparam logic [8:0]  StackMax    = 9'd256;
	localparam logic [8:0]  ReduceLimit = 9'd256;
	localparam logic [15:0] ActLast     = 16'hFFFF;
	localparam logic [7:0]  EndReset    = 8'd36;

	typedef struct packed {
		op_t        op;
		logic [7:0] cell_state;
		logic [7:0] symbol;
		kind_t      kind;
		logic [7:0] target;
		logic [7:0] rule_number;
		logic [3:0] rule_position;
		logic [7:0] rule_left;
		logic [4:0] rule_length;
		logic       is_end;
	} item_t;

	typedef struct packed {
		logic     valid;
		verdict_t verdict;
		cause_t   cause;
	} res_t;
endpackage

// ===== rtl/core/lrp_front.sv =====
// Front end: accepts items, classifies them and queues them for the engine
module lrp_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [1:0]          cmd,
	input  logic [7:0]          cell_state,
	input  logic [7:0]          symbol,
	input  logic [1:0]          action_kind,
	input  logic [7:0]          action_target,
	input  logic [7:0]          rule_number,
	input  logic [3:0]          rule_position,
	input  logic [7:0]          rule_left,
	input  logic [4:0]          rule_length,
	input  logic [7:0]          end_symbol,
	input  logic                clearing,
	input  logic                take,
	output logic                head_valid,
	output lrp_pkg::item_t      head
);
	lrp_pkg::item_t q_q [2];
	logic           wptr_q, rptr_q;
	logic [1:0]     cnt_q;
	lrp_pkg::item_t cls;
	logic           acc;

	always_comb begin
		cls.op            = lrp_pkg::op_t'(cmd);
		cls.cell_state    = cell_state;
		cls.symbol        = symbol;
		cls.kind          = lrp_pkg::kind_t'(action_kind);
		cls.target        = action_target;
		cls.rule_number   = rule_number;
		cls.rule_position = rule_position;
		cls.rule_left     = rule_left;
		cls.rule_length   = (rule_length > lrp_pkg::RhsMax) ? lrp_pkg::RhsMax : rule_length;
		cls.is_end        = (symbol == end_symbol);
	end

	assign full       = (cnt_q == 2'd2) || clearing;
	assign acc        = push && !full;
	assign head_valid = (cnt_q != 2'd0);
	assign head       = q_q[rptr_q];

	always_ff @(posedge clk) begin
		if (acc) begin
			q_q[wptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (acc) begin
				wptr_q <= ~wptr_q;
			end
			if (take) begin
				rptr_q <= ~rptr_q;
			end
			cnt_q <= cnt_q + {1'b0, acc} - {1'b0, take};
		end
	end
endmodule

// ===== rtl/core/lrp_back.sv =====
// Back end: table stores, parse stack and the shift-reduce sequencer
`include "lr_table_parse_engine_top_assert.svh"
module lrp_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	input  lrp_pkg::item_t item,
	output logic           item_pop,
	input  logic           out_space,
	output logic           clearing,
	output lrp_pkg::res_t  res
);
	lrp_pkg::state_t state_q, state_d;
	lrp_pkg::item_t  cur_q;
	logic [8:0]      cnt_q, red_q;
	logic [7:0]      top_q, rule_q, left_q;
	logic [4:0]      len_q;
	logic            rej_q, acc_q;
	lrp_pkg::cause_t rcause_q;
	logic [15:0]     clr_q;

	logic [9:0]  act_mem [65536];
	logic [15:0] stk_mem [256];
	logic [12:0] rh_mem [256];
	logic [7:0]  rs_mem [4096];
	logic [9:0]  act_rd_q;
	logic [15:0] stk_rd_q;
	logic [12:0] rh_rd_q;
	logic [7:0]  rs_rd_q;

	logic        act_we, stk_we, rh_we, rs_we;
	logic [15:0] act_wa, act_ra;
	logic [9:0]  act_wd;
	logic [7:0]  stk_wa, stk_ra;
	logic [15:0] stk_wd;
	logic [7:0]  rh_ra;
	logic [11:0] rs_wa, rs_ra;

	lrp_pkg::kind_t  rd_kind;
	logic [7:0]      rd_tgt;
	logic [4:0]      hd_len;
	logic [8:0]      cnt_m1, cnt_m2;
	logic            start, fail, mism;
	lrp_pkg::cause_t fail_cause;

	assign rd_kind  = lrp_pkg::kind_t'(act_rd_q[9:8]);
	assign rd_tgt   = act_rd_q[7:0];
	assign hd_len   = rh_rd_q[12:8];
	assign cnt_m1   = cnt_q - 9'd1;
	assign cnt_m2   = cnt_q - 9'd2;
	assign mism     = (stk_rd_q[7:0] != rs_rd_q);
	assign start    = (state_q == lrp_pkg::ST_IDLE) && item_valid && out_space;
	assign item_pop = start;
	assign clearing = (state_q == lrp_pkg::ST_CLEAR);

	always_comb begin
		state_d = state_q;
		case (state_q)
			lrp_pkg::ST_CLEAR: begin
				if (clr_q == lrp_pkg::ActLast) state_d = lrp_pkg::ST_IDLE;
			end
			lrp_pkg::ST_IDLE: begin
				if (start && item.op == lrp_pkg::OP_PARSE) begin
					state_d = rej_q ? lrp_pkg::ST_FINISH : lrp_pkg::ST_LOOK;
				end
			end
			lrp_pkg::ST_LOOK: begin
				if (rd_kind == lrp_pkg::KIND_REDUCE && red_q != lrp_pkg::ReduceLimit) begin
					state_d = lrp_pkg::ST_HEAD;
				end else begin
					state_d = lrp_pkg::ST_FINISH;
				end
			end
			lrp_pkg::ST_HEAD: begin
				if (hd_len == 5'd0) state_d = lrp_pkg::ST_GOTO;
				else if (cnt_q == 9'd0) state_d = lrp_pkg::ST_FINISH;
				else state_d = lrp_pkg::ST_POP;
			end
			lrp_pkg::ST_POP: begin
				if (mism) state_d = lrp_pkg::ST_FINISH;
				else if (len_q == 5'd0) begin
					state_d = (cnt_q == 9'd1) ? lrp_pkg::ST_GOTO : lrp_pkg::ST_TOPRD;
				end else if (cnt_q == 9'd1) state_d = lrp_pkg::ST_FINISH;
				else state_d = lrp_pkg::ST_POP;
			end
			lrp_pkg::ST_TOPRD: state_d = lrp_pkg::ST_GOTO;
			lrp_pkg::ST_GOTO: begin
				if (rd_kind != lrp_pkg::KIND_SHIFT || cnt_q == lrp_pkg::StackMax) begin
					state_d = lrp_pkg::ST_FINISH;
				end else begin
					state_d = lrp_pkg::ST_LOOK;
				end
			end
			lrp_pkg::ST_FINISH: state_d = lrp_pkg::ST_IDLE;
			default: state_d = lrp_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		act_we     = 1'b0;
		act_wa     = {item.cell_state, item.symbol};
		act_wd     = {item.kind, item.target};
		act_ra     = {top_q, cur_q.symbol};
		stk_we     = 1'b0;
		stk_wa     = cnt_q[7:0];
		stk_wd     = {rd_tgt, cur_q.symbol};
		stk_ra     = cnt_m1[7:0];
		rh_we      = 1'b0;
		rh_ra      = rd_tgt;
		rs_we      = 1'b0;
		rs_wa      = {item.rule_number, item.rule_position};
		rs_ra      = {rule_q, len_q[3:0] - 4'd1};
		fail       = 1'b0;
		fail_cause = lrp_pkg::C_NONE;
		res        = '{valid: 1'b0, verdict: lrp_pkg::V_NONE, cause: lrp_pkg::C_NONE};
		case (state_q)
			lrp_pkg::ST_CLEAR: begin
				act_we = 1'b1;
				act_wa = clr_q;
				act_wd = '0;
			end
			lrp_pkg::ST_IDLE: begin
				act_ra = {top_q, item.symbol};
				if (start) begin
					case (item.op)
						lrp_pkg::OP_CELL: act_we = 1'b1;
						lrp_pkg::OP_HEAD: rh_we = 1'b1;
						lrp_pkg::OP_RSYM: rs_we = 1'b1;
						default: ;
					endcase
					res.valid = (item.op != lrp_pkg::OP_PARSE);
				end
			end
			lrp_pkg::ST_LOOK: begin
				case (rd_kind)
					lrp_pkg::KIND_EMPTY: begin
						fail       = 1'b1;
						fail_cause = lrp_pkg::C_NO_ACTION;
					end
					lrp_pkg::KIND_ACCEPT: begin
						fail       = !cur_q.is_end;
						fail_cause = lrp_pkg::C_NO_ACTION;
					end
					lrp_pkg::KIND_SHIFT: begin
						if (cur_q.is_end) begin
							fail       = 1'b1;
							fail_cause = lrp_pkg::C_NO_ACTION;
						end else if (cnt_q == lrp_pkg::StackMax) begin
							fail       = 1'b1;
							fail_cause = lrp_pkg::C_LIMIT;
						end else begin
							stk_we = 1'b1;
						end
					end
					default: begin
						if (red_q == lrp_pkg::ReduceLimit) begin
							fail       = 1'b1;
							fail_cause = lrp_pkg::C_LIMIT;
						end
					end
				endcase
			end
			lrp_pkg::ST_HEAD: begin
				act_ra = {top_q, rh_rd_q[7:0]};
				stk_ra = cnt_m1[7:0];
				rs_ra  = {rule_q, hd_len[3:0] - 4'd1};
				if (hd_len != 5'd0 && cnt_q == 9'd0) begin
					fail       = 1'b1;
					fail_cause = lrp_pkg::C_MISMATCH;
				end
			end
			lrp_pkg::ST_POP: begin
				stk_ra = cnt_m2[7:0];
				act_ra = {8'd0, left_q};
				if (mism || (len_q != 5'd0 && cnt_q == 9'd1)) begin
					fail       = 1'b1;
					fail_cause = lrp_pkg::C_MISMATCH;
				end
			end
			lrp_pkg::ST_TOPRD: begin
				act_ra = {stk_rd_q[15:8], left_q};
			end
			lrp_pkg::ST_GOTO: begin
				act_ra = {rd_tgt, cur_q.symbol};
				stk_wd = {rd_tgt, left_q};
				if (rd_kind != lrp_pkg::KIND_SHIFT) begin
					fail       = 1'b1;
					fail_cause = lrp_pkg::C_MISMATCH;
				end else if (cnt_q == lrp_pkg::StackMax) begin
					fail       = 1'b1;
					fail_cause = lrp_pkg::C_LIMIT;
				end else begin
					stk_we = 1'b1;
				end
			end
			lrp_pkg::ST_FINISH: begin
				res.valid = 1'b1;
				if (cur_q.is_end) begin
					if (rej_q) begin
						res.verdict = lrp_pkg::V_REJECT;
						res.cause   = rcause_q;
					end else if (acc_q) begin
						res.verdict = lrp_pkg::V_ACCEPT;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (act_we) act_mem[act_wa] <= act_wd;
		act_rd_q <= act_mem[act_ra];
		if (stk_we) stk_mem[stk_wa] <= stk_wd;
		stk_rd_q <= stk_mem[stk_ra];
		if (rh_we) rh_mem[item.rule_number] <= {item.rule_length, item.rule_left};
		rh_rd_q <= rh_mem[rh_ra];
		if (rs_we) rs_mem[rs_wa] <= item.symbol;
		rs_rd_q <= rs_mem[rs_ra];
	end

	always_ff @(posedge clk) begin
		case (state_q)
			lrp_pkg::ST_IDLE: begin
				cur_q <= item;
				red_q <= 9'd0;
				acc_q <= 1'b0;
			end
			lrp_pkg::ST_LOOK: begin
				rule_q <= rd_tgt;
				red_q  <= red_q + 9'd1;
				if (rd_kind == lrp_pkg::KIND_ACCEPT && cur_q.is_end) acc_q <= 1'b1;
			end
			lrp_pkg::ST_HEAD: begin
				left_q <= rh_rd_q[7:0];
				len_q  <= hd_len - 5'd1;
			end
			lrp_pkg::ST_POP: begin
				len_q <= len_q - 5'd1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= lrp_pkg::ST_CLEAR;
			clr_q    <= '0;
			cnt_q    <= 9'd0;
			top_q    <= 8'd0;
			rej_q    <= 1'b0;
			rcause_q <= lrp_pkg::C_NONE;
		end else begin
			state_q <= state_d;
			if (clearing) clr_q <= clr_q + 16'd1;
			if (stk_we) cnt_q <= cnt_q + 9'd1;
			if (fail) begin
				rej_q    <= 1'b1;
				rcause_q <= fail_cause;
			end
			case (state_q)
				lrp_pkg::ST_LOOK: if (stk_we) top_q <= rd_tgt;
				lrp_pkg::ST_GOTO: if (stk_we) top_q <= rd_tgt;
				lrp_pkg::ST_POP: begin
					if (!mism) cnt_q <= cnt_m1;
					if (!mism && cnt_q == 9'd1) top_q <= 8'd0;
				end
				lrp_pkg::ST_TOPRD: top_q <= stk_rd_q[15:8];
				lrp_pkg::ST_FINISH: begin
					if (cur_q.is_end) begin
						cnt_q    <= 9'd0;
						top_q    <= 8'd0;
						rej_q    <= 1'b0;
						rcause_q <= lrp_pkg::C_NONE;
					end
				end
				default: ;
			endcase
		end
	end

	`LRP_ASSERT_IMP(a_cnt_range, 1'b1, cnt_q <= lrp_pkg::StackMax)
	`LRP_ASSERT_IMP(a_no_take_clear, state_q == lrp_pkg::ST_CLEAR, !item_pop)
	`LRP_ASSERT_IMP(a_rej_cause, rej_q, rcause_q != lrp_pkg::C_NONE)
	`LRP_ASSERT_NEXT(a_end_resets, state_q == lrp_pkg::ST_FINISH && cur_q.is_end, cnt_q == 9'd0)
endmodule

// ===== rtl/core/lr_table_parse_engine_top.sv =====
// Flow: a table write gives its result as the engine takes it; a parse symbol passes LOOK and
// FINISH (only FINISH once its string is rejected) and, per reduction, HEAD, one POP per
// right-side symbol popped, TOPRD when entries stay above the bottom after the pops, and GOTO.
// Throughput: one item at a time in the engine: a table write per cycle while the output queue
// has space and no clear runs; a parse symbol ends before the engine takes the next item.
// Reset: after arst_n rises the action table is cleared over 65536 cycles with full high;
// end_symbol resets to 36 and the stack to its bottom entry.
module lr_table_parse_engine_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [1:0] cmd,
	input  logic [7:0] cell_state,
	input  logic [7:0] symbol,
	input  logic [1:0] action_kind,
	input  logic [7:0] action_target,
	input  logic [7:0] rule_number,
	input  logic [3:0] rule_position,
	input  logic [7:0] rule_left,
	input  logic [4:0] rule_length,
	output logic       empty,
	input  logic       pop,
	output logic [1:0] verdict,
	output logic [1:0] reject_cause,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata
);
	logic [7:0]     end_symbol_q;
	logic           clearing, head_valid, take;
	lrp_pkg::item_t head;
	lrp_pkg::res_t  res;
	lrp_pkg::res_t  oq_q [2];
	logic           owptr_q, orptr_q;
	logic [1:0]     ocnt_q;
	logic           odeq;

	lrp_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.cmd(cmd), .cell_state(cell_state), .symbol(symbol),
		.action_kind(action_kind), .action_target(action_target),
		.rule_number(rule_number), .rule_position(rule_position),
		.rule_left(rule_left), .rule_length(rule_length),
		.end_symbol(end_symbol_q), .clearing(clearing), .take(take),
		.head_valid(head_valid), .head(head)
	);

	lrp_back u_back (
		.clk(clk), .arst_n(arst_n), .item_valid(head_valid), .item(head),
		.item_pop(take), .out_space(ocnt_q != 2'd2), .clearing(clearing), .res(res)
	);

	assign empty        = (ocnt_q == 2'd0);
	assign odeq         = pop && !empty;
	assign verdict      = oq_q[orptr_q].verdict;
	assign reject_cause = oq_q[orptr_q].cause;

	always_ff @(posedge clk) begin
		if (res.valid) oq_q[owptr_q] <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_symbol_q <= lrp_pkg::EndReset;
			owptr_q      <= 1'b0;
			orptr_q      <= 1'b0;
			ocnt_q       <= 2'd0;
		end else begin
			if (cfg_we) end_symbol_q <= cfg_wdata;
			if (res.valid) owptr_q <= ~owptr_q;
			if (odeq) orptr_q <= ~orptr_q;
			ocnt_q <= ocnt_q + {1'b0, res.valid} - {1'b0, odeq};
		end
	end
endmodule
